/* src/lrm_pkg.sv */
`default_nettype none
package lrm_pkg;

    localparam int BLOCK_COUNT = 32;
    localparam int STAMP_BITS  = 32;
    localparam int PIN_BITS    = 16;
    localparam int ID_W        = 5;
    localparam int LIMIT_W     = 6;

    typedef logic [ID_W-1:0]       block_id_t;
    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [PIN_BITS-1:0]   pin_t;
    typedef logic [LIMIT_W-1:0]    count_t;

    typedef enum logic [2:0] {
        KIND_ENSURE  = 3'd0,
        KIND_MAP     = 3'd1,
        KIND_UNMAP   = 3'd2,
        KIND_FRESH   = 3'd3,
        KIND_RELEASE = 3'd4,
        KIND_DEMOTE  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NO_ROOM = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_EVICT,
        S_EXEC,
        S_PIN
    } state_t;

    // Update broadcast to every cell; only the cell whose index matches acts.
    typedef struct packed {
        block_id_t id;
        logic      set_res;
        logic      clr_res;
        logic      pin_inc;
        logic      pin_dec;
        logic      pin_clr;
        logic      stamp_we;
        stamp_t    stamp_val;
    } cell_cmd_t;

    // Running oldest-candidate wave passed from cell to cell.
    typedef struct packed {
        logic      valid;
        logic      found;
        stamp_t    stamp;
        block_id_t idx;
    } scan_t;

endpackage
`default_nettype wire

/* src/lrm_cell.sv */
`default_nettype none
module lrm_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lrm_pkg::block_id_t idx,
    input  wire lrm_pkg::cell_cmd_t cmd,
    input  wire lrm_pkg::scan_t     scan_in,
    output lrm_pkg::scan_t          scan_out,
    output logic                    resident
);
    import lrm_pkg::*;

    logic   res_reg, res_next;
    pin_t   pin_reg, pin_next;
    stamp_t stamp_reg, stamp_next;
    scan_t  scan_reg, scan_next;
    logic   hit, eligible;

    assign hit      = (cmd.id == idx);
    assign eligible = res_reg && (pin_reg == '0) && (cmd.id != idx);

    always_comb
    begin
        res_next   = res_reg;
        pin_next   = pin_reg;
        stamp_next = stamp_reg;
        if (hit)
        begin
            if (cmd.set_res)
                res_next = 1'b1;
            if (cmd.clr_res)
                res_next = 1'b0;
            if (cmd.pin_clr)
                pin_next = '0;
            else if (cmd.pin_inc && (pin_reg != '1))
                pin_next = pin_reg + 1'b1;
            else if (cmd.pin_dec && (pin_reg != '0))
                pin_next = pin_reg - 1'b1;
            if (cmd.stamp_we)
                stamp_next = cmd.stamp_val;
        end
        // strict compare keeps the lower index on a tie
        scan_next = scan_in;
        if (scan_in.valid && eligible && (!scan_in.found || (stamp_reg < scan_in.stamp)))
        begin
            scan_next.found = 1'b1;
            scan_next.stamp = stamp_reg;
            scan_next.idx   = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg   <= 1'b0;
            pin_reg   <= '0;
            stamp_reg <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            res_reg   <= res_next;
            pin_reg   <= pin_next;
            stamp_reg <= stamp_next;
            scan_reg  <= scan_next;
        end
    end

    assign scan_out = scan_reg;
    assign resident = res_reg;

endmodule
`default_nettype wire

/* src/lru_residency_manager.sv */
`default_nettype none
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       tuser kind, tdata block_id, block_valid
// m_*       out  m_tvalid / m_tready       tuser status, tdata result_block, tier;
//                                          tlast last
// cfg_*     in   cfg_valid / cfg_ready     cfg_data fast-tier block limit
//
// One item is taken at a time. A hit or a non-allocating event goes from accept
// through the decide and execute steps, where its result is registered, and then
// frees the input; map adds a pin step, and an invalid block is answered from the
// decide step. Each eviction adds one pass of the victim wave down the row of 32
// cells plus an evict step to retire the victim.
// Reset clears all residency, pins, stamps and counters and loads limit 32.
// A stalled result holds the controller at its next item-producing step; a scan
// in progress runs on regardless.
module lru_residency_manager (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [4:0] block_id, [5] block_valid, [7:6] zero
    input  wire logic [2:0] s_tuser,   // [2:0] kind
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [4:0] result_block, [5] tier, [7:6] zero
    output logic [1:0]      m_tuser,   // [1:0] status
    output logic            m_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [5:0] cfg_data
);
    import lrm_pkg::*;

    state_t    state_reg, state_next;
    logic [2:0] kind_reg, kind_next;
    block_id_t id_reg, id_next;
    logic      bvalid_reg, bvalid_next;
    count_t    total_reg, total_next;
    count_t    limit_reg;
    stamp_t    ctr_reg, ctr_next;
    block_id_t victim_reg, victim_next;
    logic      found_reg, found_next;

    logic      out_valid_reg, out_valid_next;
    logic [5:0] out_data_reg, out_data_next;
    logic [1:0] out_user_reg, out_user_next;
    logic      out_last_reg, out_last_next;

    cell_cmd_t cmd;
    scan_t     chain [BLOCK_COUNT+1];
    logic [BLOCK_COUNT-1:0] res_flags;
    logic      wave_start;
    logic      out_free;
    logic      tgt_res;
    logic      needs_valid;
    stamp_t    stamp_inc;

    // Row of cells: the victim wave enters at cell 0 and leaves at the end.
    assign chain[0] = {wave_start, 1'b0, stamp_t'(0), block_id_t'(0)};

    for (genvar g = 0; g < BLOCK_COUNT; g++)
    begin : g_cell
        lrm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (ID_W'(g)),
            .cmd      (cmd),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1]),
            .resident (res_flags[g])
        );
    end

    assign out_free    = !out_valid_reg || m_tready;
    assign tgt_res     = res_flags[id_reg];
    assign stamp_inc   = (ctr_reg == '1) ? ctr_reg : ctr_reg + 1'b1;
    assign needs_valid = (kind_reg == KIND_ENSURE) || (kind_reg == KIND_MAP) ||
                         (kind_reg == KIND_UNMAP)  || (kind_reg == KIND_DEMOTE);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        bvalid_next    = bvalid_reg;
        total_next     = total_reg;
        ctr_next       = ctr_reg;
        victim_next    = victim_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        wave_start     = 1'b0;
        cmd            = '0;
        cmd.id         = id_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next   = s_tuser;
                    id_next     = s_tdata[4:0];
                    bvalid_next = s_tdata[5];
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (kind_reg > 3'(KIND_DEMOTE))
                    state_next = S_IDLE;
                else if ((32'(id_reg) >= BLOCK_COUNT) || (!bvalid_reg && needs_valid))
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_user_next  = ST_INVALID;
                        out_data_next  = {(32'(id_reg) >= BLOCK_COUNT) || !tgt_res, id_reg};
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (((kind_reg == KIND_ENSURE) || (kind_reg == KIND_MAP)) &&
                         !tgt_res && (total_reg >= limit_reg))
                begin
                    wave_start = 1'b1;
                    state_next = S_SCAN;
                end
                else
                    state_next = S_EXEC;
            end
            S_SCAN:
            begin
                cmd.id = id_reg;   // excluded from victim choice
                if (chain[BLOCK_COUNT].valid)
                begin
                    found_next  = chain[BLOCK_COUNT].found;
                    victim_next = chain[BLOCK_COUNT].idx;
                    state_next  = S_EVICT;
                end
            end
            S_EVICT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        cmd.id         = victim_reg;
                        cmd.clr_res    = 1'b1;
                        total_next     = total_reg - 1'b1;
                        out_user_next  = ST_OK;
                        out_data_next  = {1'b1, victim_reg};
                        out_last_next  = 1'b0;
                        if ((total_reg - 1'b1) >= limit_reg)
                        begin
                            wave_start = 1'b1;
                            state_next = S_SCAN;
                        end
                        else
                            state_next = S_EXEC;
                    end
                    else
                    begin
                        out_user_next = ST_NO_ROOM;
                        out_data_next = {1'b1, id_reg};
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_user_next = ST_OK;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                    unique case (kind_reg)
                        3'(KIND_ENSURE), 3'(KIND_MAP):
                        begin
                            if (!tgt_res)
                            begin
                                cmd.set_res = 1'b1;
                                total_next  = total_reg + 1'b1;
                            end
                            cmd.stamp_we  = 1'b1;
                            cmd.stamp_val = stamp_inc;
                            ctr_next      = stamp_inc;
                            if (kind_reg == 3'(KIND_MAP))
                                state_next = S_PIN;
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = {1'b0, id_reg};
                            end
                        end
                        3'(KIND_UNMAP):
                        begin
                            cmd.pin_dec    = 1'b1;
                            cmd.stamp_we   = 1'b1;
                            cmd.stamp_val  = stamp_inc;
                            ctr_next       = stamp_inc;
                            out_valid_next = 1'b1;
                            out_data_next  = {!tgt_res, id_reg};
                        end
                        3'(KIND_FRESH):
                        begin
                            cmd.pin_clr    = 1'b1;
                            cmd.stamp_we   = 1'b1;
                            out_valid_next = 1'b1;
                            if (total_reg < limit_reg)
                            begin
                                if (!tgt_res)
                                begin
                                    cmd.set_res = 1'b1;
                                    total_next  = total_reg + 1'b1;
                                end
                                cmd.stamp_val = stamp_inc;
                                ctr_next      = stamp_inc;
                                out_data_next = {1'b0, id_reg};
                            end
                            else
                            begin
                                cmd.clr_res = 1'b1;
                                if (tgt_res)
                                    total_next = total_reg - 1'b1;
                                out_data_next = {1'b1, id_reg};
                            end
                        end
                        3'(KIND_RELEASE):
                        begin
                            cmd.clr_res    = 1'b1;
                            cmd.pin_clr    = 1'b1;
                            cmd.stamp_we   = 1'b1;
                            if (tgt_res)
                                total_next = total_reg - 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = {1'b1, id_reg};
                        end
                        default:
                        begin
                            // demote: pins are not checked
                            cmd.clr_res = 1'b1;
                            if (tgt_res)
                                total_next = total_reg - 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = {1'b1, id_reg};
                        end
                    endcase
                end
            end
            S_PIN:
            begin
                if (out_free)
                begin
                    cmd.pin_inc    = 1'b1;
                    cmd.stamp_we   = 1'b1;
                    cmd.stamp_val  = stamp_inc;
                    ctr_next       = stamp_inc;
                    out_valid_next = 1'b1;
                    out_user_next  = ST_OK;
                    out_data_next  = {1'b0, id_reg};
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            ctr_reg       <= '0;
            limit_reg     <= 6'd32;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        bvalid_reg   <= bvalid_next;
        victim_reg   <= victim_next;
        found_reg    <= found_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // resident count tracks the flags held in the cells
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(res_flags) == 32'(total_reg))
        else $error("resident count out of step with cell flags");

    // a wave only leaves the row while the controller waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        chain[BLOCK_COUNT].valid |-> (state_reg == S_SCAN))
        else $error("victim wave arrived outside scan");

    // an eviction item always reports the slow tier
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[5] && (m_tuser == ST_OK)))
        else $error("eviction item malformed");

endmodule
`default_nettype wire
